// ----- rtl/push_relabel_max_flow_assert.svh -----
// Assertion macros used by the max-flow RTL.
`ifndef PUSH_RELABEL_MAX_FLOW_ASSERT_SVH
`define PUSH_RELABEL_MAX_FLOW_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/prmf_pkg.sv -----
// Package: constants and opcodes of the push-relabel max-flow engine.
package prmf_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int VCNT_W       = 7;
    localparam int CAP_W        = 32;
    localparam int FLOW_W       = 40;
    localparam int EXC_W        = 40;
    localparam int HGT_W        = 8;
    localparam int RES_W        = 34;
    localparam int MF_W         = 38;
    localparam int ADDR_W       = 2 * VTX_W;

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_RUN   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;
endpackage

// ----- rtl/prmf_if.sv -----
// Interfaces: request channel and result channel.
interface prmf_req_if import prmf_pkg::*; ();
    logic             valid;
    logic             ready;
    t_op              op;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic [CAP_W-1:0] edge_capacity;
    logic [VTX_W-1:0] source_vertex;
    logic [VTX_W-1:0] sink_vertex;

    modport source (output valid, op, from_vertex, to_vertex, edge_capacity,
                    source_vertex, sink_vertex, input ready);
    modport sink   (input valid, op, from_vertex, to_vertex, edge_capacity,
                    source_vertex, sink_vertex, output ready);
endinterface

interface prmf_res_if import prmf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MF_W-1:0] total_flow;
    logic            bad_request;

    modport source (output valid, total_flow, bad_request, input ready);
    modport sink   (input valid, total_flow, bad_request, output ready);
endinterface

// ----- rtl/push_relabel_max_flow.sv -----
// Max-flow engine: FIFO push-relabel over a 64x64 capacity matrix held in RAM.
// Capacity write items go straight into the RAM while the engine is idle. After
// reset, and after a clear item, all 4096 capacity entries are swept to zero with
// the request channel stalled. A run item first sweeps the flow RAM, then saturates
// the source edges and discharges the active FIFO; every matrix access is a
// registered RAM read, so a scan step passes CHK, RD and EVAL, a push PUSH1 to
// PUSH3, and a relabel reads the neighbours in LIFT before LEND. The run length
// is data dependent and the request channel is stalled throughout. A rejected
// run (bad vertex or source equal to sink) answers with a zero flow and bad_request set.
`include "push_relabel_max_flow_assert.svh"

module push_relabel_max_flow import prmf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_wdata,
    prmf_req_if.sink          i_req,
    prmf_res_if.source        o_res
);
    localparam logic [4:0] ST_CCLR  = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_RCLR  = 5'd2;
    localparam logic [4:0] ST_SRCH  = 5'd3;
    localparam logic [4:0] ST_CHK   = 5'd4;
    localparam logic [4:0] ST_RD    = 5'd5;
    localparam logic [4:0] ST_EVAL  = 5'd6;
    localparam logic [4:0] ST_PUSH1 = 5'd7;
    localparam logic [4:0] ST_PUSH2 = 5'd8;
    localparam logic [4:0] ST_PUSH3 = 5'd9;
    localparam logic [4:0] ST_LIFT  = 5'd10;
    localparam logic [4:0] ST_LEND  = 5'd11;
    localparam logic [4:0] ST_WB    = 5'd12;
    localparam logic [4:0] ST_NEXT  = 5'd13;
    localparam logic [4:0] ST_POP   = 5'd14;
    localparam logic [4:0] ST_POP2  = 5'd15;
    localparam logic [4:0] ST_LOAD  = 5'd16;
    localparam logic [4:0] ST_FIN   = 5'd17;
    localparam logic [4:0] ST_FIN2  = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    localparam logic [HGT_W:0] NO_BEST = '1;

    // Memories
    logic [CAP_W-1:0]  cap_mem  [2**ADDR_W];
    logic [FLOW_W-1:0] flow_mem [2**ADDR_W];
    logic [HGT_W-1:0]  hgt_mem  [MAX_VERTICES];
    logic [EXC_W-1:0]  exc_mem  [MAX_VERTICES];
    logic [VCNT_W-1:0] scn_mem  [MAX_VERTICES];
    logic [VTX_W-1:0]  q_mem    [MAX_VERTICES];

    logic [CAP_W-1:0]  cap_rd;
    logic [FLOW_W-1:0] flow_rd;
    logic [HGT_W-1:0]  hgt_rd;
    logic [EXC_W-1:0]  exc_rd;
    logic [VCNT_W-1:0] scn_rd;
    logic [VTX_W-1:0]  q_rd;

    // Control and working registers
    logic [4:0]        r_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [VCNT_W-1:0] r_vcnt, r_n, r_scan, r_li, r_qcnt;
    logic [VTX_W-1:0]  r_s, r_t, r_u, r_qhead;
    logic              r_src;
    logic [EXC_W-1:0]  r_exc_u, r_exc_v;
    logic [HGT_W-1:0]  r_hu;
    logic [HGT_W:0]    r_best;
    logic [FLOW_W-1:0] r_flow, r_fvu;
    logic [RES_W-1:0]  r_r, r_d;
    logic              r_ov, r_bad, r_rbad;
    logic [MF_W-1:0]   r_mf, r_res;

    // Memory ports
    logic [ADDR_W-1:0] cap_ra, flow_ra, cap_wa, flow_wa;
    logic [VTX_W-1:0]  vtx_ra, h_wa, e_wa, sc_wa, q_wa, v_idx;
    logic              cap_we, flow_we, h_we, e_we, sc_we, q_we;
    logic [CAP_W-1:0]  cap_wd;
    logic [FLOW_W-1:0] flow_wd;
    logic [HGT_W-1:0]  h_wd;
    logic [EXC_W-1:0]  e_wd;
    logic [VCNT_W-1:0] sc_wd;

    logic              accept, req_bad, push_ok, enq, lift_hit;
    logic [VCNT_W-1:0] n_cur;
    logic [FLOW_W:0]   res_full;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign v_idx = r_scan[VTX_W-1:0];

    // Vertex count in use, saturated to the built size
    assign n_cur = (r_vcnt > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcnt;
    assign req_bad = ({1'b0, i_req.source_vertex} >= n_cur)
                  || ({1'b0, i_req.sink_vertex} >= n_cur)
                  || (i_req.source_vertex == i_req.sink_vertex);

    // Residual test and value for the edge just read
    assign res_full = {{(FLOW_W+1-CAP_W){1'b0}}, cap_rd} - {flow_rd[FLOW_W-1], flow_rd};
    assign push_ok  = ($signed(flow_rd) < $signed({{(FLOW_W-CAP_W){1'b0}}, cap_rd}))
                   && (r_hu > hgt_rd);
    assign lift_hit = ($signed(flow_rd) < $signed({{(FLOW_W-CAP_W){1'b0}}, cap_rd}))
                   && ({1'b0, hgt_rd} < r_best);
    assign enq = (v_idx != r_s) && (r_exc_v == '0) && (r_qcnt < VCNT_W'(MAX_VERTICES));

    // Read addresses
    always_comb begin
        cap_ra  = {r_u, v_idx};
        flow_ra = {r_u, v_idx};
        vtx_ra  = v_idx;
        if (r_state == ST_LIFT) begin
            cap_ra  = {r_u, r_li[VTX_W-1:0]};
            flow_ra = {r_u, r_li[VTX_W-1:0]};
            vtx_ra  = r_li[VTX_W-1:0];
        end else if (r_state == ST_PUSH1) begin
            flow_ra = {v_idx, r_u};
        end else if (r_state == ST_POP2) begin
            vtx_ra = q_rd;
        end else if (r_state == ST_FIN) begin
            vtx_ra = r_t;
        end
    end

    // Write ports
    always_comb begin
        cap_we  = 1'b0;
        cap_wa  = r_cnt;
        cap_wd  = '0;
        flow_we = 1'b0;
        flow_wa = r_cnt;
        flow_wd = '0;
        h_we    = 1'b0;
        h_wa    = r_cnt[VTX_W-1:0];
        h_wd    = '0;
        e_we    = 1'b0;
        e_wa    = r_cnt[VTX_W-1:0];
        e_wd    = '0;
        sc_we   = 1'b0;
        sc_wa   = r_cnt[VTX_W-1:0];
        sc_wd   = '0;
        q_we    = 1'b0;
        q_wa    = r_qhead + r_qcnt[VTX_W-1:0];
        unique case (r_state)
            ST_CCLR: cap_we = 1'b1;
            ST_IDLE: begin
                cap_we = accept && (i_req.op == OP_WRITE);
                cap_wa = {i_req.from_vertex, i_req.to_vertex};
                cap_wd = i_req.edge_capacity;
            end
            ST_RCLR: begin
                flow_we = 1'b1;
                h_we    = (r_cnt[ADDR_W-1:VTX_W] == '0);
                e_we    = h_we;
                sc_we   = h_we;
            end
            ST_SRCH: begin
                h_we = 1'b1;
                h_wa = r_s;
                h_wd = HGT_W'(r_n);
            end
            ST_PUSH2: begin
                flow_we = 1'b1;
                flow_wa = {r_u, v_idx};
                flow_wd = r_flow + FLOW_W'(r_d);
            end
            ST_PUSH3: begin
                flow_we = 1'b1;
                flow_wa = {v_idx, r_u};
                flow_wd = r_fvu - FLOW_W'(r_d);
                e_we    = (v_idx != r_s);
                e_wa    = v_idx;
                e_wd    = r_exc_v + EXC_W'(r_d);
                q_we    = enq;
            end
            ST_LEND: begin
                h_we = (r_best != NO_BEST);
                h_wa = r_u;
                h_wd = r_best[HGT_W-1:0] + HGT_W'(1);
            end
            ST_WB: begin
                e_we  = 1'b1;
                e_wa  = r_u;
                e_wd  = r_exc_u;
                sc_we = 1'b1;
                sc_wa = r_u;
                sc_wd = r_scan;
            end
            default: ;
        endcase
    end

    // RAMs with registered reads
    always_ff @(posedge i_clk) begin
        if (cap_we) cap_mem[cap_wa] <= cap_wd;
        if (flow_we) flow_mem[flow_wa] <= flow_wd;
        if (h_we) hgt_mem[h_wa] <= h_wd;
        if (e_we) exc_mem[e_wa] <= e_wd;
        if (sc_we) scn_mem[sc_wa] <= sc_wd;
        if (q_we) q_mem[q_wa] <= v_idx;
        cap_rd  <= cap_mem[cap_ra];
        flow_rd <= flow_mem[flow_ra];
        hgt_rd  <= hgt_mem[vtx_ra];
        exc_rd  <= exc_mem[vtx_ra];
        scn_rd  <= scn_mem[vtx_ra];
        q_rd    <= q_mem[r_qhead];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= VCNT_W'(MAX_VERTICES);
        end else if (i_cfg_we) begin
            r_vcnt <= i_cfg_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CCLR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_qcnt  <= '0;
            r_qhead <= '0;
            r_src   <= 1'b0;
        end else begin
            // result taken; a new result in ST_OUT reloads the register instead
            if (o_res.valid && o_res.ready && r_state != ST_OUT) r_ov <= 1'b0;
            unique case (r_state)
                ST_CCLR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == '1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cnt <= '0;
                        if (i_req.op == OP_CLEAR) begin
                            r_state <= ST_CCLR;
                        end else if (i_req.op == OP_RUN) begin
                            r_s    <= i_req.source_vertex;
                            r_t    <= i_req.sink_vertex;
                            r_n    <= n_cur;
                            r_res  <= '0;
                            r_rbad <= req_bad;
                            r_state <= req_bad ? ST_OUT : ST_RCLR;
                        end
                    end
                end
                ST_RCLR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == '1) r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    r_u     <= r_s;
                    r_hu    <= HGT_W'(r_n);
                    r_exc_u <= '1;
                    r_scan  <= '0;
                    r_src   <= 1'b1;
                    r_qhead <= '0;
                    r_qcnt  <= '0;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_exc_u == '0) r_state <= ST_WB;
                    else if (r_scan < r_n) r_state <= ST_RD;
                    else if (r_src) r_state <= ST_NEXT;
                    else begin
                        r_li    <= '0;
                        r_best  <= NO_BEST;
                        r_state <= ST_LIFT;
                    end
                end
                ST_RD: r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_flow  <= flow_rd;
                    r_exc_v <= exc_rd;
                    r_r     <= res_full[RES_W-1:0];
                    if (push_ok) begin
                        r_state <= ST_PUSH1;
                    end else begin
                        r_scan  <= r_scan + VCNT_W'(1);
                        r_state <= ST_CHK;
                    end
                end
                ST_PUSH1: begin
                    r_d <= (r_exc_u < EXC_W'(r_r)) ? r_exc_u[RES_W-1:0] : r_r;
                    r_state <= ST_PUSH2;
                end
                ST_PUSH2: begin
                    r_fvu   <= flow_rd;
                    r_state <= ST_PUSH3;
                end
                ST_PUSH3: begin
                    r_exc_u <= r_exc_u - EXC_W'(r_d);
                    if (enq) r_qcnt <= r_qcnt + VCNT_W'(1);
                    r_state <= ST_CHK;
                end
                ST_LIFT: begin
                    if (r_li != '0 && lift_hit) r_best <= {1'b0, hgt_rd};
                    if (r_li == r_n) r_state <= ST_LEND;
                    else r_li <= r_li + VCNT_W'(1);
                end
                ST_LEND: begin
                    if (r_best != NO_BEST) r_hu <= r_best[HGT_W-1:0] + HGT_W'(1);
                    r_scan  <= '0;
                    r_state <= ST_CHK;
                end
                ST_WB: r_state <= ST_NEXT;
                ST_NEXT: r_state <= (r_qcnt != '0) ? ST_POP : ST_FIN;
                ST_POP: begin
                    r_qhead <= r_qhead + VTX_W'(1);
                    r_qcnt  <= r_qcnt - VCNT_W'(1);
                    r_state <= ST_POP2;
                end
                ST_POP2: begin
                    r_u   <= q_rd;
                    r_src <= 1'b0;
                    r_state <= (q_rd == r_s || q_rd == r_t) ? ST_NEXT : ST_LOAD;
                end
                ST_LOAD: begin
                    r_exc_u <= exc_rd;
                    r_hu    <= hgt_rd;
                    r_scan  <= scn_rd;
                    r_state <= ST_CHK;
                end
                ST_FIN: r_state <= ST_FIN2;
                ST_FIN2: begin
                    r_res   <= exc_rd[MF_W-1:0];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_mf    <= r_res;
                        r_bad   <= r_rbad;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.total_flow  = r_mf;
    assign o_res.bad_request = r_bad;

    // Checks
    `PRMF_ASSERT_NOW(a_qcnt_bound, 1'b1, r_qcnt <= VCNT_W'(MAX_VERTICES), "queue overflow")
    `PRMF_ASSERT_NOW(a_pop_nonempty, r_state == ST_POP, r_qcnt != '0, "pop from empty queue")
    `PRMF_ASSERT_NOW(a_scan_excess, r_state == ST_RD, r_exc_u != '0, "scan without excess")
    `PRMF_ASSERT_NOW(a_push_amount, r_state == ST_PUSH3, r_d != '0, "push of zero flow")
    `PRMF_ASSERT_NEXT(a_push_drop, r_state == ST_PUSH3, r_state == ST_CHK, "push not rechecked")
endmodule

// ----- bench/prmf_checker.sv -----
// Checker: watches the max-flow channels, predicts each result and compares it.
module prmf_checker import prmf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_wdata,
    prmf_req_if               req_mon,
    prmf_res_if               res_mon,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [MF_W-1:0] total_flow;
        logic            bad_request;
    } flow_answer_t;

    localparam longint SUPPLY = longint'(1) <<< 62;

    flow_answer_t     answer_q[$];
    logic [CAP_W-1:0] cap_mem [MAX_VERTICES][MAX_VERTICES];
    longint           flow_mem[MAX_VERTICES][MAX_VERTICES];
    int unsigned      height  [MAX_VERTICES];
    longint           excess  [MAX_VERTICES];
    int unsigned      scan    [MAX_VERTICES];
    int unsigned      fifo    [MAX_VERTICES];
    int unsigned      fifo_head, fifo_cnt;
    logic [VCNT_W-1:0] vcount;
    int               mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = answer_q.size();

    function automatic longint resid(int unsigned u, int unsigned v);
        return longint'({32'b0, cap_mem[u][v]}) - flow_mem[u][v];
    endfunction

    function automatic void push_edge(int unsigned u, int unsigned v);
        longint r, d;
        r = resid(u, v);
        d = (excess[u] < r) ? excess[u] : r;
        if (d <= 0) return;
        flow_mem[u][v] += d;
        flow_mem[v][u] -= d;
        excess[u] -= d;
        excess[v] += d;
        // newly active vertex joins the FIFO if there is room
        if (excess[v] == d && fifo_cnt < MAX_VERTICES) begin
            fifo[(fifo_head + fifo_cnt) % MAX_VERTICES] = v;
            fifo_cnt++;
        end
    endfunction

    function automatic void discharge(int unsigned u, int unsigned n);
        int unsigned lowest, v;
        while (excess[u] > 0) begin
            if (scan[u] < n) begin
                v = scan[u];
                if (resid(u, v) > 0 && height[u] > height[v]) push_edge(u, v);
                else scan[u]++;
            end else begin
                // relabel: one above the lowest residual neighbor
                lowest = 32'hFFFF_FFFF;
                for (int unsigned i = 0; i < n; i++)
                    if (resid(u, i) > 0 && height[i] < lowest) lowest = height[i];
                if (lowest != 32'hFFFF_FFFF) height[u] = lowest + 1;
                scan[u] = 0;
            end
        end
    endfunction

    function automatic logic [MF_W-1:0] solve_flow(int unsigned s, int unsigned t,
                                                   int unsigned n);
        longint total;
        int unsigned u;
        total = 0;
        foreach (flow_mem[i, j]) flow_mem[i][j] = 0;
        foreach (height[i]) begin
            height[i] = 0;
            excess[i] = 0;
            scan[i]   = 0;
        end
        fifo_head = 0;
        fifo_cnt  = 0;
        height[s] = n;
        excess[s] = SUPPLY;
        for (int unsigned i = 0; i < n; i++)
            if (i != s) push_edge(s, i);
        while (fifo_cnt > 0) begin
            u = fifo[fifo_head];
            fifo_head = (fifo_head + 1) % MAX_VERTICES;
            fifo_cnt--;
            if (u != s && u != t) discharge(u, n);
        end
        for (int unsigned i = 0; i < n; i++) total += flow_mem[i][t];
        return total[MF_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        int unsigned n;
        flow_answer_t want;
        if (!i_rst_n) begin
            foreach (cap_mem[i, j]) cap_mem[i][j] = '0;
            vcount    = 7'd64;
            fifo_head = 0;
            fifo_cnt  = 0;
            answer_q.delete();
            mismatches = 0;
        end else begin
            // request side: update the model per accepted item
            if (req_mon.valid && req_mon.ready) begin
                case (req_mon.op)
                    OP_WRITE: cap_mem[req_mon.from_vertex][req_mon.to_vertex] =
                                  req_mon.edge_capacity;
                    OP_CLEAR: foreach (cap_mem[i, j]) cap_mem[i][j] = '0;
                    OP_RUN: begin
                        n = (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
                        if (req_mon.source_vertex >= n || req_mon.sink_vertex >= n ||
                            req_mon.source_vertex == req_mon.sink_vertex) begin
                            want = '{total_flow: '0, bad_request: 1'b1};
                        end else begin
                            want.total_flow = solve_flow(req_mon.source_vertex,
                                                         req_mon.sink_vertex, n);
                            want.bad_request = 1'b0;
                        end
                        answer_q.push_back(want);
                    end
                    default: ;
                endcase
            end
            // register write takes effect after this edge
            if (i_cfg_we) vcount = i_cfg_wdata;
            // result side: compare against the oldest expected item
            if (res_mon.valid && res_mon.ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: flow %0d bad %0d",
                                 res_mon.total_flow, res_mon.bad_request);
                end else begin
                    want = answer_q.pop_front();
                    if (res_mon.total_flow !== want.total_flow ||
                        res_mon.bad_request !== want.bad_request) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: flow exp %0d got %0d, bad exp %0d got %0d",
                                     want.total_flow, res_mon.total_flow,
                                     want.bad_request, res_mon.bad_request);
                    end
                end
            end
        end
    end
endmodule

// ----- bench/tb_push_relabel_max_flow.sv -----
// Testbench top: stimulus, result backpressure and final verdict for the max-flow engine.
module tb_push_relabel_max_flow;
    import prmf_pkg::*;

    localparam int CYCLE_LIMIT = 50_000_000;
    localparam int SETTLE      = 4300;   // covers a matrix sweep after a clear

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [VCNT_W-1:0] i_cfg_wdata = '0;
    int                fail_count, pending, cycles;
    int                hold_off = 0;
    int unsigned       n_cur = 64;

    prmf_req_if req();
    prmf_res_if res();

    push_relabel_max_flow DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_req(req), .o_res(res)
    );

    prmf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .req_mon(req), .res_mon(res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, occasional long hold-off on request
    initial begin
        int stall;
        stall = 0;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                res.ready <= 1'b0;
                hold_off  = hold_off - 1;
            end else if (stall > 0) begin
                res.ready <= 1'b0;
                stall--;
            end else begin
                res.ready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                        : $urandom_range(1, 4);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until accepted
    task automatic send(t_op op, int unsigned a, int unsigned b, logic [CAP_W-1:0] c,
                        int unsigned s, int unsigned t);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid         <= 1'b1;
        req.op            <= op;
        req.from_vertex   <= VTX_W'(a);
        req.to_vertex     <= VTX_W'(b);
        req.edge_capacity <= c;
        req.source_vertex <= VTX_W'(s);
        req.sink_vertex   <= VTX_W'(t);
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic write_cap(int unsigned a, int unsigned b, logic [CAP_W-1:0] c);
        send(OP_WRITE, a, b, c, $urandom, $urandom);
    endtask

    task automatic run_flow(int unsigned s, int unsigned t);
        send(OP_RUN, $urandom, $urandom, $urandom, s, t);
    endtask

    // stop offering, let every result arrive and the engine go quiet
    task automatic drain_all();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(int unsigned v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= VCNT_W'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cur = (v < MAX_VERTICES) ? v : MAX_VERTICES;
    endtask

    function automatic logic [CAP_W-1:0] rand_cap();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 20);
        if (r < 7) return '0;
        if (r < 8) return '1;
        return $urandom;
    endfunction

    initial begin
        int unsigned n_items, nv, s, t, k;
        req.valid = 1'b0;
        req.op = OP_WRITE;
        req.from_vertex = '0;
        req.to_vertex = '0;
        req.edge_capacity = '0;
        req.source_vertex = '0;
        req.sink_vertex = '0;
        cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: four-vertex graph with extreme capacities
        set_vertex_count(4);
        write_cap(0, 1, '1);
        write_cap(0, 2, '1);
        write_cap(1, 3, '1);
        write_cap(2, 3, '1);
        write_cap(1, 1, 32'd7);          // self loop
        write_cap(1, 2, 32'd5);
        write_cap(0, 2, 32'd9);          // overwrite same pair
        write_cap(63, 63, 32'h5555_AAAA); // outside active vertices
        send(t_op'(2'd3), 63, 0, '1, 63, 63); // unknown op, ignored
        run_flow(0, 3);
        run_flow(3, 0);
        run_flow(2, 2);                  // source equals sink
        run_flow(4, 3);                  // source out of range
        run_flow(0, 63);                 // sink out of range
        drain_all();
        send(OP_CLEAR, 0, 0, 0, 0, 0);
        run_flow(0, 3);                  // empty matrix gives zero flow
        drain_all();
        set_vertex_count(0);             // every run rejected
        run_flow(0, 1);
        drain_all();
        set_vertex_count(127);           // saturates to the full size
        write_cap(0, 63, '1);
        write_cap(5, 63, 32'd3);
        write_cap(0, 5, 32'd10);
        run_flow(0, 63);
        drain_all();

        // long result hold-off while runs keep coming
        set_vertex_count(2);
        write_cap(0, 1, 32'd42);
        hold_off = 15000;
        repeat (4) run_flow(0, 1);
        drain_all();

        // random phases
        n_items = 0;
        while (n_items < 1200) begin
            k = $urandom_range(0, 19);
            if (k == 0) nv = 64;
            else if (k == 1) nv = $urandom_range(0, 1);
            else if (k == 2) nv = 127;
            else if (k < 5) nv = $urandom_range(9, 16);
            else nv = $urandom_range(2, 8);
            set_vertex_count(nv);
            if ($urandom_range(0, 3) == 0) begin
                send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
                n_items++;
            end
            k = (n_cur > 16) ? $urandom_range(10, 24) : $urandom_range(3, 16);
            repeat (k) begin
                if ($urandom_range(0, 9) == 0)
                    write_cap($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (n_cur >= 1)
                    write_cap($urandom_range(0, n_cur - 1), $urandom_range(0, n_cur - 1),
                              rand_cap());
                if ($urandom_range(0, 19) == 0)
                    send(t_op'(2'd3), $urandom, $urandom, $urandom, $urandom, $urandom);
                n_items++;
            end
            repeat ($urandom_range(1, 3)) begin
                if (n_cur >= 2 && $urandom_range(0, 4) != 0) begin
                    s = $urandom_range(0, n_cur - 1);
                    t = $urandom_range(0, n_cur - 1);
                end else begin
                    s = $urandom_range(0, 63);
                    t = $urandom_range(0, 63);
                end
                run_flow(s, t);
                n_items++;
            end
            drain_all();
        end

        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
